// ===== hdl/vmec_pkg.sv =====
// vmec_pkg: types and constants for the execute core
// no dependencies
package vmec_pkg;
   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE, ST_EXEC,
      ST_BLOCK_LD, ST_BLOCK_LD_WR, ST_BLOCK_ST, ST_RESPOND
   } state_type;

   localparam logic [11:0] START_RESET = 12'h200;
   localparam logic [3:0] OP_SYS   = 4'h0;
   localparam logic [3:0] OP_JP    = 4'h1;
   localparam logic [3:0] OP_CALL  = 4'h2;
   localparam logic [3:0] OP_SEB   = 4'h3;
   localparam logic [3:0] OP_SNEB  = 4'h4;
   localparam logic [3:0] OP_SER   = 4'h5;
   localparam logic [3:0] OP_LDB   = 4'h6;
   localparam logic [3:0] OP_ADDB  = 4'h7;
   localparam logic [3:0] OP_ALU   = 4'h8;
   localparam logic [3:0] OP_SNER  = 4'h9;
   localparam logic [3:0] OP_LDI   = 4'hA;
   localparam logic [3:0] OP_JPV   = 4'hB;
   localparam logic [3:0] OP_RND   = 4'hC;
   localparam logic [3:0] OP_DRW   = 4'hD;
   localparam logic [3:0] OP_KEY   = 4'hE;
   localparam logic [3:0] OP_MISC  = 4'hF;

   localparam logic [15:0] OPW_CLS = 16'h00E0;
   localparam logic [15:0] OPW_RET = 16'h00EE;

   localparam logic [7:0] KK_SKP   = 8'h9E;
   localparam logic [7:0] KK_SKNP  = 8'hA1;
   localparam logic [7:0] KK_GETDT = 8'h07;
   localparam logic [7:0] KK_WAITK = 8'h0A;
   localparam logic [7:0] KK_SETDT = 8'h15;
   localparam logic [7:0] KK_SETST = 8'h18;
   localparam logic [7:0] KK_ADDI  = 8'h1E;
   localparam logic [7:0] KK_FONT  = 8'h29;
   localparam logic [7:0] KK_BCD   = 8'h33;
   localparam logic [7:0] KK_STORE = 8'h55;
   localparam logic [7:0] KK_LOAD  = 8'h65;

   localparam logic [3:0] ALU_LD  = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;
endpackage

// ===== hdl/vmec_req_if.sv =====
// vmec_req_if: request channel carrying one load or step item
// no dependencies
interface vmec_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [11:0] load_address;
   logic [7:0]  load_data;
   logic [7:0]  random_byte;
   modport source (output valid, kind, load_address, load_data, random_byte, input ready);
   modport sink   (input valid, kind, load_address, load_data, random_byte, output ready);
endinterface

// ===== hdl/vmec_rsp_if.sv =====
// vmec_rsp_if: response channel carrying the machine state after an item
// no dependencies
interface vmec_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] program_counter;
   logic [15:0] executed_opcode;
   logic [11:0] index_value;
   logic [7:0]  delay_value;
   logic [7:0]  sound_value;
   logic        unknown_opcode;
   modport source (output valid, program_counter, executed_opcode, index_value,
                   delay_value, sound_value, unknown_opcode, input ready);
   modport sink   (input valid, program_counter, executed_opcode, index_value,
                   delay_value, sound_value, unknown_opcode, output ready);
endinterface

// ===== hdl/virtual_machine_execute_core.sv =====
// virtual_machine_execute_core: chip8 style cpu with internal byte memory
// depends on vmec_pkg, vmec_req_if, vmec_rsp_if
//
// usage
//  req channel: each item is a load (kind 0, writes load_data at load_address)
//  or a step (kind 1, fetches the big-endian word at the pc and executes it)
//  rsp channel: one item per request: pc, opcode, index, timers, unknown flag
//  csr port: csr_write_enable/csr_write_data set the pc
//  sequence: a load goes through exec (memory write) and respond; a step
//  through fetch_hi, fetch_lo, decode, exec and respond (two byte reads of
//  the main memory, decode with the register file read, execute); Fx55
//  repeats block_st and Fx65 block_ld/block_ld_wr per register moved, since
//  the single memory port moves one byte per cycle; one item is in flight at
//  a time; the next is accepted once the response register has the previous result
//  reset: control state, registers V0..VF (by valid bits), return stack
//  (valid bits), stack pointer 15, pc = start address; main memory is not
//  cleared and must be loaded before being read
//  rsp stall: the response register holds; one more item may be accepted and
//  waits with its finished result until the register drains
module virtual_machine_execute_core
   import vmec_pkg::*;
#(
   parameter int MEMORY_DEPTH = 4096,
   parameter int STACK_DEPTH  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [11:0]  csr_write_data,
   vmec_req_if.sink     req,
   vmec_rsp_if.source   rsp
);
   localparam int MAW = $clog2(MEMORY_DEPTH);
   localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // main memory, one port, registered read
   logic [7:0]     mem [MEMORY_DEPTH];
   logic [MAW-1:0] mem_addr;
   logic           mem_we;
   logic [7:0]     mem_wdata;
   logic [7:0]     mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   // general registers: small array with valid bits for the zero reset
   logic [7:0]  v_ff [16];
   logic [15:0] v_valid_ff;
   // return stack with valid bits
   logic [11:0]            stk_ff [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] stk_valid_ff;

   state_type   state_ff, state_in;
   logic [11:0] pc_ff, index_ff;
   logic [7:0]  delay_ff, sound_ff;
   logic [SPW-1:0] sp_ff;
   logic [15:0] op_ff;
   logic        kind_ff;
   logic [11:0] laddr_ff;
   logic [7:0]  ldata_ff, rnd_ff;
   logic [3:0]  cnt_ff;
   logic [7:0]  vx_ff, vy_ff, v0_ff;
   logic        unk_ff;

   logic        rsp_valid_ff;
   logic [11:0] rsp_pc_ff, rsp_idx_ff;
   logic [15:0] rsp_op_ff;
   logic [7:0]  rsp_dt_ff, rsp_st_ff;
   logic        rsp_unk_ff;

   logic [3:0] op_x, op_y, op_n, op_hi;
   logic [7:0] op_kk;
   logic [11:0] op_nnn, pc_next2;
   assign op_hi  = op_ff[15:12];
   assign op_x   = op_ff[11:8];
   assign op_y   = op_ff[7:4];
   assign op_n   = op_ff[3:0];
   assign op_kk  = op_ff[7:0];
   assign op_nnn = op_ff[11:0];
   assign pc_next2 = pc_ff + 12'd2;

   logic rsp_free;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);
   logic accept;
   assign accept = req.valid && req.ready;

   // reduce to the memory depth: parallel compares against constant multiples
   function automatic logic [MAW-1:0] maddr(input logic [11:0] a);
      logic [12:0] base;
      logic [12:0] r;
      base = '0;
      for (int k = 1; k <= 4096 / MEMORY_DEPTH; k++) begin
         if ({1'b0, a} >= 13'(k * MEMORY_DEPTH)) base = 13'(k * MEMORY_DEPTH);
      end
      r = {1'b0, a} - base;
      return r[MAW-1:0];
   endfunction

   // memory address selection
   logic [11:0] blk_addr;
   assign blk_addr = index_ff + {8'd0, cnt_ff};
   always_comb begin
      mem_addr  = maddr(pc_ff);
      mem_we    = 1'b0;
      mem_wdata = ldata_ff;
      case (state_ff)
         ST_IDLE:     mem_addr = maddr(pc_ff);
         ST_FETCH_HI: mem_addr = maddr(pc_ff + 12'd1);
         ST_EXEC: begin
            if (!kind_ff) begin
               mem_addr = maddr(laddr_ff);
               mem_we   = 1'b1;
            end else begin
               mem_addr = maddr(blk_addr);
            end
         end
         ST_BLOCK_LD: mem_addr = maddr(blk_addr);
         ST_BLOCK_ST: begin
            mem_addr  = maddr(blk_addr);
            mem_we    = 1'b1;
            mem_wdata = v_valid_ff[cnt_ff] ? v_ff[cnt_ff] : 8'd0;
         end
         default: ;
      endcase
   end

   logic is_store, is_load;
   assign is_store = (op_hi == OP_MISC) && (op_kk == KK_STORE);
   assign is_load  = (op_hi == OP_MISC) && (op_kk == KK_LOAD);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (accept) state_in = req.kind ? ST_FETCH_HI : ST_EXEC;
         ST_FETCH_HI:    state_in = ST_FETCH_LO;
         ST_FETCH_LO:    state_in = ST_DECODE;
         ST_DECODE:      state_in = ST_EXEC;
         ST_EXEC: begin
            if (kind_ff && is_store)     state_in = ST_BLOCK_ST;
            else if (kind_ff && is_load) state_in = ST_BLOCK_LD;
            else                         state_in = ST_RESPOND;
         end
         ST_BLOCK_ST:    state_in = (cnt_ff == op_x) ? ST_RESPOND : ST_BLOCK_ST;
         ST_BLOCK_LD:    state_in = ST_BLOCK_LD_WR;
         ST_BLOCK_LD_WR: state_in = (cnt_ff == op_x) ? ST_RESPOND : ST_BLOCK_LD;
         ST_RESPOND:     if (rsp_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // execute decode
   logic [7:0]  vx_wdata, vf_wdata;
   logic        vx_we, vf_we, unk_c, skip_c;
   logic [11:0] jump_pc, idx_c;
   logic        jump_c, call_c, ret_c;
   logic [8:0]  sum9;
   logic [7:0]  dt_c, st_c;
   always_comb begin
      vx_wdata = 8'd0; vf_wdata = 8'd0; vx_we = 1'b0; vf_we = 1'b0;
      unk_c = 1'b0; skip_c = 1'b0; jump_c = 1'b0; call_c = 1'b0; ret_c = 1'b0;
      jump_pc = op_nnn; idx_c = index_ff; dt_c = delay_ff; st_c = sound_ff;
      sum9 = {1'b0, vx_ff} + {1'b0, vy_ff};
      case (op_hi)
         OP_SYS: begin
            if (op_ff == OPW_RET) ret_c = 1'b1;
            else if (op_ff != OPW_CLS) unk_c = 1'b1;
         end
         OP_JP:   jump_c = 1'b1;
         OP_CALL: call_c = 1'b1;
         OP_SEB:  skip_c = (vx_ff == op_kk);
         OP_SNEB: skip_c = (vx_ff != op_kk);
         OP_SER:  skip_c = (vx_ff == vy_ff);
         OP_SNER: skip_c = (vx_ff != vy_ff);
         OP_LDB:  begin vx_we = 1'b1; vx_wdata = op_kk; end
         OP_ADDB: begin vx_we = 1'b1; vx_wdata = vx_ff + op_kk; end
         OP_ALU: begin
            vx_we = 1'b1;
            case (op_n)
               ALU_LD:  vx_wdata = vy_ff;
               ALU_OR:  vx_wdata = vx_ff | vy_ff;
               ALU_AND: vx_wdata = vx_ff & vy_ff;
               ALU_XOR: vx_wdata = vx_ff ^ vy_ff;
               ALU_ADD: begin vx_wdata = sum9[7:0]; vf_we = 1'b1; vf_wdata = {7'd0, sum9[8]}; end
               ALU_SUB: begin
                  vx_wdata = vx_ff - vy_ff; vf_we = 1'b1;
                  vf_wdata = {7'd0, vx_ff >= vy_ff};
               end
               ALU_SHR: begin vx_wdata = vx_ff >> 1; vf_we = 1'b1; vf_wdata = {7'd0, vx_ff[0]}; end
               ALU_SBN: begin
                  vx_wdata = vy_ff - vx_ff; vf_we = 1'b1;
                  vf_wdata = {7'd0, vy_ff >= vx_ff};
               end
               ALU_SHL: begin vx_wdata = vx_ff << 1; vf_we = 1'b1; vf_wdata = {7'd0, vx_ff[7]}; end
               default: begin vx_we = 1'b0; unk_c = 1'b1; end
            endcase
         end
         OP_LDI: idx_c = op_nnn;
         OP_JPV: begin jump_c = 1'b1; jump_pc = op_nnn + {4'd0, v0_ff}; end
         OP_RND: begin vx_we = 1'b1; vx_wdata = rnd_ff & op_kk; end
         OP_DRW: ;
         OP_KEY: unk_c = (op_kk != KK_SKP) && (op_kk != KK_SKNP);
         default: begin
            case (op_kk)
               KK_GETDT: begin vx_we = 1'b1; vx_wdata = delay_ff; end
               KK_SETDT: dt_c = vx_ff;
               KK_SETST: st_c = vx_ff;
               KK_ADDI:  idx_c = index_ff + {4'd0, vx_ff};
               KK_WAITK, KK_FONT, KK_BCD, KK_STORE, KK_LOAD: ;
               default: unk_c = 1'b1;
            endcase
         end
      endcase
   end

   // flag write wins over the vx write when x is vf
   logic vx_wr_ok;
   assign vx_wr_ok = vx_we && !(vf_we && (op_x == 4'd15));

   logic [SPW-1:0] sp_inc, sp_dec;
   assign sp_inc = (sp_ff == SPW'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
   assign sp_dec = (sp_ff == '0) ? SPW'(STACK_DEPTH - 1) : sp_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= START_RESET;
         index_ff     <= '0;
         delay_ff     <= '0;
         sound_ff     <= '0;
         sp_ff        <= SPW'(STACK_DEPTH - 1);
         v_valid_ff   <= '0;
         stk_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end
         if ((state_ff == ST_RESPOND) && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp.ready)                      rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_EXEC: if (kind_ff) begin
               if (vx_wr_ok) v_valid_ff[op_x] <= 1'b1;
               if (vf_we)    v_valid_ff[15]   <= 1'b1;
               index_ff <= idx_c;
               delay_ff <= dt_c;
               sound_ff <= st_c;
               if (call_c) begin
                  sp_ff <= sp_inc;
                  stk_valid_ff[sp_inc] <= 1'b1;
                  pc_ff <= op_nnn;
               end else if (ret_c) begin
                  sp_ff <= sp_dec;
                  pc_ff <= stk_valid_ff[sp_ff] ? stk_ff[sp_ff] : 12'd0;
               end else if (jump_c) begin
                  pc_ff <= jump_pc;
               end else begin
                  pc_ff <= skip_c ? pc_next2 + 12'd2 : pc_next2;
               end
            end
            ST_BLOCK_LD_WR: v_valid_ff[cnt_ff] <= 1'b1;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (accept) begin
            kind_ff  <= req.kind;
            laddr_ff <= req.load_address;
            ldata_ff <= req.load_data;
            rnd_ff   <= req.random_byte;
            op_ff    <= '0;
            unk_ff   <= 1'b0;
         end
         // byte at pc was read in idle, byte at pc+1 in fetch_hi
         ST_FETCH_HI: op_ff[15:8] <= mem_rdata_ff;
         ST_FETCH_LO: op_ff[7:0]  <= mem_rdata_ff;
         ST_DECODE: begin
            vx_ff <= v_valid_ff[op_x] ? v_ff[op_x] : 8'd0;
            vy_ff <= v_valid_ff[op_y] ? v_ff[op_y] : 8'd0;
            v0_ff <= v_valid_ff[0] ? v_ff[0] : 8'd0;
         end
         ST_EXEC: begin
            cnt_ff <= '0;
            unk_ff <= kind_ff & unk_c;
            if (kind_ff) begin
               if (vx_wr_ok) v_ff[op_x] <= vx_wdata;
               if (vf_we)    v_ff[15]   <= vf_wdata;
               if (call_c) stk_ff[sp_inc] <= pc_next2;
            end
         end
         ST_BLOCK_ST: cnt_ff <= cnt_ff + 4'd1;
         ST_BLOCK_LD_WR: begin
            v_ff[cnt_ff] <= mem_rdata_ff;
            cnt_ff <= cnt_ff + 4'd1;
         end
         ST_RESPOND: if (rsp_free) begin
            rsp_pc_ff  <= pc_ff;
            rsp_op_ff  <= op_ff;
            rsp_idx_ff <= index_ff;
            rsp_dt_ff  <= delay_ff;
            rsp_st_ff  <= sound_ff;
            rsp_unk_ff <= unk_ff;
         end
         default: ;
      endcase
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.program_counter = rsp_pc_ff;
   assign rsp.executed_opcode = rsp_op_ff;
   assign rsp.index_value     = rsp_idx_ff;
   assign rsp.delay_value     = rsp_dt_ff;
   assign rsp.sound_value     = rsp_st_ff;
   assign rsp.unknown_opcode  = rsp_unk_ff;
endmodule

// ===== hdl/vmec_checker.sv =====
// vmec_checker: port level checks for the execute core
// depends on the ports of virtual_machine_execute_core
module vmec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_executed_opcode,
   input logic        rsp_unknown_opcode
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_executed_opcode))
      else $error("rsp dropped");
   a_no_accept_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second item accepted");
   a_no_rsp_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid || $past(rsp_valid))
      else $error("response too early");
   // a load taken with the response register empty is answered after exec and respond
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind && !rsp_valid |-> ##3
      (rsp_valid && rsp_executed_opcode == 16'd0 && !rsp_unknown_opcode))
      else $error("bad load response");
endmodule

bind virtual_machine_execute_core vmec_checker u_vmec_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_kind(req.kind),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_executed_opcode(rsp.executed_opcode),
   .rsp_unknown_opcode(rsp.unknown_opcode)
);
